[rtl/nsf_pkg.sv]
// Package: command, character, width and timing constants of the NMEA sentence framer.
package nsf_pkg;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_POLL = 1'b1;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_LOW    = 8'h20;
    localparam logic [7:0] CHR_HIGH   = 8'h7E;

    localparam int         LEN_OUT_W   = 7;
    localparam int         TYPE_OUT_W  = 40;
    localparam int         TIME_W      = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [TIME_W-1:0] AGE_NEVER     = 32'hFFFF_FFFF;

    typedef logic [TIME_W-1:0] t_time;

endpackage

[rtl/nmea_sentence_framer.sv]
// NMEA sentence framer: byte classification, type capture, counters and ages, result register.
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_cmd, i_data_byte, i_now_ms
//  out       output     o_out_valid / i_out_stall    o_sentence_done .. o_sentence_age_ms
//  cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data (detect timeout, ms)
//
// One item per cycle unless o_in_stall is high: each item is decoded against the framing
// state in one pass and its result lands in the output register on the accepting edge.
// The output register frees itself when taken, so a new item is accepted in the same
// cycle the held result leaves; o_in_stall is high only while a result waits under stall.
// Reset (synchronous, active low) clears the framing state, counters, seen flags and
// sets the timeout to 5000 ms. Configuration writes are taken in any cycle.
module nmea_sentence_framer #(
    parameter int SENTENCE_CAPACITY = 128,
    parameter int TYPE_CHARS        = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_now_ms,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sentence_done,
    output logic [6:0]  o_sentence_length,
    output logic [39:0] o_last_type,
    output logic        o_char_stored,
    output logic [7:0]  o_stored_char,
    output logic [6:0]  o_char_index,
    output logic [31:0] o_sentence_count,
    output logic        o_traffic_detected,
    output logic        o_packet_detected,
    output logic [31:0] o_byte_age_ms,
    output logic [31:0] o_sentence_age_ms,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int LW  = $clog2(SENTENCE_CAPACITY);
    localparam int CW  = $clog2(TYPE_CHARS + 1);
    localparam int TW  = 8 * TYPE_CHARS;
    localparam int OLW = nsf_pkg::LEN_OUT_W;
    localparam int OTW = nsf_pkg::TYPE_OUT_W;
    localparam logic [LW:0] CAP = (LW + 1)'(SENTENCE_CAPACITY);

    // framing state
    logic              r_in_sentence, n_in_sentence;
    logic              r_collecting,  n_collecting;
    logic [CW-1:0]     r_type_count,  n_type_count;
    logic [TW-1:0]     r_type_chars,  n_type_chars;
    logic [LW-1:0]     r_len,         n_len;
    logic [OTW-1:0]    r_kept_type,   n_kept_type;
    logic              r_byte_seen,   n_byte_seen;
    nsf_pkg::t_time    r_byte_time,   n_byte_time;
    logic              r_sent_seen,   n_sent_seen;
    nsf_pkg::t_time    r_sent_time,   n_sent_time;
    nsf_pkg::t_time    r_count,       n_count;
    nsf_pkg::t_time    r_timeout;

    // result register
    logic              r_out_valid;
    logic              r_done;
    logic [OLW-1:0]    r_rep_len;
    logic              r_stored;
    logic [7:0]        r_schar;
    logic [OLW-1:0]    r_sidx;
    nsf_pkg::t_time    r_bage, r_sage;
    logic              r_traffic, r_packet;

    logic              accept;
    logic              done, stored, is_term, is_print, is_sep;
    logic [7:0]        schar;
    logic [LW-1:0]     sidx, rep_len;
    logic [LW+OLW-1:0] rep_len_ext, sidx_ext;
    logic [TW+OTW-1:0] type_ext;
    nsf_pkg::t_time    bage, sage;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_collecting  = r_collecting;
        n_type_count  = r_type_count;
        n_type_chars  = r_type_chars;
        n_len         = r_len;
        n_kept_type   = r_kept_type;
        n_byte_seen   = r_byte_seen;
        n_byte_time   = r_byte_time;
        n_sent_seen   = r_sent_seen;
        n_sent_time   = r_sent_time;
        n_count       = r_count;
        done          = 1'b0;
        stored        = 1'b0;
        schar         = 8'd0;
        sidx          = '0;
        rep_len       = r_len;
        type_ext      = '0;

        is_term  = (i_data_byte == nsf_pkg::CHR_CR) || (i_data_byte == nsf_pkg::CHR_LF);
        is_print = (i_data_byte >= nsf_pkg::CHR_LOW) && (i_data_byte <= nsf_pkg::CHR_HIGH);
        is_sep   = (i_data_byte == nsf_pkg::CHR_COMMA) || (i_data_byte == nsf_pkg::CHR_STAR);

        if (i_cmd == nsf_pkg::CMD_BYTE) begin
            n_byte_seen = 1'b1;
            n_byte_time = i_now_ms;
            if (i_data_byte == nsf_pkg::CHR_DOLLAR) begin
                // restart: drop any unfinished sentence
                n_in_sentence = 1'b1;
                n_collecting  = 1'b1;
                n_type_count  = '0;
                n_type_chars  = '0;
                n_len         = LW'(1);
                stored        = 1'b1;
                schar         = i_data_byte;
                rep_len       = LW'(1);
            end else if (r_in_sentence) begin
                if (is_term) begin
                    if (r_len > LW'(1)) begin
                        done        = 1'b1;
                        n_sent_seen = 1'b1;
                        n_sent_time = i_now_ms;
                        n_count     = r_count + 32'd1;
                        if (r_type_count != '0) begin
                            type_ext    = {{OTW{1'b0}}, r_type_chars};
                            n_kept_type = type_ext[OTW-1:0];
                        end
                    end
                    rep_len       = r_len;
                    n_in_sentence = 1'b0;
                    n_collecting  = 1'b0;
                    n_type_count  = '0;
                    n_type_chars  = '0;
                    n_len         = '0;
                end else if (is_print) begin
                    // hold the length at capacity minus one, keep collecting the type
                    if (({1'b0, r_len} + (LW + 1)'(1)) < CAP) begin
                        stored = 1'b1;
                        schar  = i_data_byte;
                        sidx   = r_len;
                        n_len  = r_len + LW'(1);
                    end
                    if (r_collecting) begin
                        if (is_sep) begin
                            n_collecting = 1'b0;
                        end else if (r_type_count < CW'(TYPE_CHARS)) begin
                            for (int k = 0; k < TYPE_CHARS; k++) begin
                                if (r_type_count == CW'(TYPE_CHARS - 1 - k)) begin
                                    n_type_chars[8*k +: 8] = i_data_byte;
                                end
                            end
                            n_type_count = r_type_count + CW'(1);
                        end else begin
                            n_collecting = 1'b0;
                        end
                    end
                    rep_len = n_len;
                end
            end
        end

        bage = n_byte_seen ? (i_now_ms - n_byte_time) : nsf_pkg::AGE_NEVER;
        sage = n_sent_seen ? (i_now_ms - n_sent_time) : nsf_pkg::AGE_NEVER;

        rep_len_ext = {{OLW{1'b0}}, rep_len};
        sidx_ext    = {{OLW{1'b0}}, sidx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_collecting  <= 1'b0;
            r_type_count  <= '0;
            r_type_chars  <= '0;
            r_len         <= '0;
            r_kept_type   <= '0;
            r_byte_seen   <= 1'b0;
            r_byte_time   <= '0;
            r_sent_seen   <= 1'b0;
            r_sent_time   <= '0;
            r_count       <= '0;
            r_timeout     <= nsf_pkg::TIMEOUT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                r_in_sentence <= n_in_sentence;
                r_collecting  <= n_collecting;
                r_type_count  <= n_type_count;
                r_type_chars  <= n_type_chars;
                r_len         <= n_len;
                r_kept_type   <= n_kept_type;
                r_byte_seen   <= n_byte_seen;
                r_byte_time   <= n_byte_time;
                r_sent_seen   <= n_sent_seen;
                r_sent_time   <= n_sent_time;
                r_count       <= n_count;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done    <= done;
            r_rep_len <= rep_len_ext[OLW-1:0];
            r_stored  <= stored;
            r_schar   <= schar;
            r_sidx    <= sidx_ext[OLW-1:0];
            r_bage    <= bage;
            r_sage    <= sage;
            r_traffic <= n_byte_seen && (bage <= r_timeout);
            r_packet  <= n_sent_seen && (sage <= r_timeout);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sentence_done    = r_done;
    assign o_sentence_length  = r_rep_len;
    assign o_last_type        = r_kept_type;
    assign o_char_stored      = r_stored;
    assign o_stored_char      = r_schar;
    assign o_char_index       = r_sidx;
    assign o_sentence_count   = r_count;
    assign o_traffic_detected = r_traffic;
    assign o_packet_detected  = r_packet;
    assign o_byte_age_ms      = r_bage;
    assign o_sentence_age_ms  = r_sage;

endmodule
